### sv/tilt_compensated_compass_heading_top_macros.svh
// assertion helpers shared by the heading block
`ifndef TILT_COMPENSATED_COMPASS_HEADING_TOP_MACROS_SVH
`define TILT_COMPENSATED_COMPASS_HEADING_TOP_MACROS_SVH

// same-cycle implication
`define TCCH_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define TCCH_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

### sv/tcch_pkg.sv
`default_nettype none
package tcch_pkg;

   localparam int CORDIC_STAGES = 16;
   localparam int NUM_ITER      = (CORDIC_STAGES < 24) ? CORDIC_STAGES : 24;

   localparam int XW     = 50;   // cordic vector width
   localparam int ZW     = 32;   // cordic angle width, 2^-24 rad
   localparam int SIDE_W = 64;   // pass-along bits in each cell
   localparam int LANES  = 2;

   localparam logic signed [ZW-1:0] PI_Z      = 32'sd52707179;
   localparam logic signed [ZW-1:0] HALF_PI_Z = 32'sd26353589;
   localparam logic signed [XW-1:0] GAIN_X    = 50'sd652032874;
   localparam logic signed [15:0]   HEAD_MAX  = 16'sd25736;

   localparam logic [25:0] PI_U     = 26'd52707179;
   localparam logic [25:0] COURSE_K = 26'd36864000;   // 2048 * 18000
   localparam longint      RECIP_L  = (longint'(36864000) << 32) / 52707179;
   localparam logic [31:0] RECIP    = 32'(RECIP_L);

   typedef enum logic {
      MODE_ROT,
      MODE_VEC
   } mode_type;

   typedef enum logic [1:0] {
      BASE_NONE,
      BASE_POS,
      BASE_NEG
   } base_type;

   typedef struct packed {
      mode_type   mode;
      logic [4:0] idx;
   } cell_ctl_type;

   typedef struct packed {
      logic signed [XW-1:0] x;
      logic signed [XW-1:0] y;
      logic signed [ZW-1:0] z;
   } lane_type;

   typedef struct packed {
      logic [13:0]        pad;
      logic signed [15:0] mx;
      logic signed [15:0] my;
      logic signed [15:0] mz;
      logic               negr;
      logic               negp;
   } side_a_type;

   typedef struct packed {
      logic [60:0] pad;
      logic        zero;
      base_type    base;
   } side_b_type;

   typedef struct packed {
      logic [30:0]        pad;
      logic signed [15:0] head;
      logic [15:0]        course;
      logic               neg;
   } side_c_type;

   function automatic logic [23:0] atan_q24(input logic [4:0] i);
      case (i)
         5'd0:    atan_q24 = 24'd13176795;
         5'd1:    atan_q24 = 24'd7778716;
         5'd2:    atan_q24 = 24'd4110060;
         5'd3:    atan_q24 = 24'd2086331;
         5'd4:    atan_q24 = 24'd1047214;
         5'd5:    atan_q24 = 24'd524117;
         5'd6:    atan_q24 = 24'd262123;
         5'd7:    atan_q24 = 24'd131069;
         5'd8:    atan_q24 = 24'd65536;
         5'd9:    atan_q24 = 24'd32768;
         5'd10:   atan_q24 = 24'd16384;
         5'd11:   atan_q24 = 24'd8192;
         5'd12:   atan_q24 = 24'd4096;
         5'd13:   atan_q24 = 24'd2048;
         5'd14:   atan_q24 = 24'd1024;
         5'd15:   atan_q24 = 24'd512;
         5'd16:   atan_q24 = 24'd256;
         5'd17:   atan_q24 = 24'd128;
         5'd18:   atan_q24 = 24'd64;
         5'd19:   atan_q24 = 24'd32;
         5'd20:   atan_q24 = 24'd16;
         5'd21:   atan_q24 = 24'd8;
         5'd22:   atan_q24 = 24'd4;
         5'd23:   atan_q24 = 24'd2;
         default: atan_q24 = 24'd0;
      endcase
   endfunction

   // q1.30 to q1.14, optional negate, round half away, clamp to +-1
   function automatic logic signed [15:0] to_q14(input logic signed [XW-1:0] v,
                                                 input logic neg);
      logic signed [XW-1:0] w;
      logic signed [XW-1:0] r;
      w = neg ? -v : v;
      if (w >= 0) begin
         r = (w + 50'sd32768) >>> 16;
      end else begin
         r = -((-w + 50'sd32768) >>> 16);
      end
      if (r > 50'sd16384) begin
         r = 50'sd16384;
      end else if (r < -50'sd16384) begin
         r = -50'sd16384;
      end
      to_q14 = 16'(r);
   endfunction

endpackage
`default_nettype wire

### sv/tcch_if.sv
`default_nettype none
interface tcch_req_if;
   logic               valid;
   logic               ready;
   logic signed [15:0] mag_x;
   logic signed [15:0] mag_y;
   logic signed [15:0] mag_z;
   logic signed [15:0] roll;
   logic signed [15:0] pitch;

   modport source (output valid, mag_x, mag_y, mag_z, roll, pitch, input ready);
   modport sink   (input valid, mag_x, mag_y, mag_z, roll, pitch, output ready);
endinterface

interface tcch_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [15:0] heading;
   logic [15:0]        course_centideg;
   logic signed [15:0] heading_cos;
   logic signed [15:0] heading_sin;

   modport source (output valid, heading, course_centideg, heading_cos, heading_sin,
                   input ready);
   modport sink   (input valid, heading, course_centideg, heading_cos, heading_sin,
                   output ready);
endinterface
`default_nettype wire

### sv/tcch_cell.sv
`default_nettype none
module tcch_cell
   import tcch_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire cell_ctl_type           ctl,
   input  wire logic                   in_valid,
   output logic                        in_ready,
   input  wire lane_type [LANES-1:0]   in_lane,
   input  wire logic [SIDE_W-1:0]      in_side,
   output logic                        out_valid,
   input  wire logic                   out_ready,
   output lane_type [LANES-1:0]        out_lane,
   output logic [SIDE_W-1:0]           out_side
);

   logic                  valid_ff;
   lane_type [LANES-1:0]  lane_ff, lane_in;
   logic [SIDE_W-1:0]     side_ff;

   // one micro-rotation per lane
   always_comb begin
      logic signed [XW-1:0] xs;
      logic signed [XW-1:0] ys;
      logic signed [ZW-1:0] a;
      logic                 dir;
      for (int l = 0; l < LANES; l++) begin
         xs = in_lane[l].x >>> ctl.idx;
         ys = in_lane[l].y >>> ctl.idx;
         a  = $signed({{(ZW-24){1'b0}}, atan_q24(ctl.idx)});
         dir = (ctl.mode == MODE_ROT) ? (in_lane[l].z >= 0) : !(in_lane[l].y > 0);
         if (dir) begin
            lane_in[l].x = in_lane[l].x - ys;
            lane_in[l].y = in_lane[l].y + xs;
            lane_in[l].z = in_lane[l].z - a;
         end else begin
            lane_in[l].x = in_lane[l].x + ys;
            lane_in[l].y = in_lane[l].y - xs;
            lane_in[l].z = in_lane[l].z + a;
         end
      end
   end

   assign in_ready = !valid_ff || out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
      if (in_ready && in_valid) begin
         lane_ff <= lane_in;
         side_ff <= in_side;
      end
   end

   assign out_valid = valid_ff;
   assign out_lane  = lane_ff;
   assign out_side  = side_ff;

endmodule
`default_nettype wire

### sv/tilt_compensated_compass_heading_top.sv
// tilt compensated compass heading
// req_if carries one magnetometer sample (mag_x/y/z) plus roll and pitch in
// q3.13 radians; rsp_if returns heading (q3.13), course in centidegrees and
// the q1.14 cosine and sine of the heading. both are valid/ready channels,
// an item moves on a clock edge with valid and ready high.
// the datapath is a chain of cordic cells: one chain rotates roll and pitch
// in two lanes, a second chain vectors the horizontal field to atan2, a third
// rotates the heading back to cos/sin. plain stages sit between the chains
// for the tilt products, the heading round and the course scaling.
// a new item can enter every cycle while the receiver keeps up, set by one
// micro-rotation per cell per cycle. each stage holds its item while the next
// one is full, so a stalled receiver backs items up stage by stage; bubbles
// collapse, and req ready drops only once every stage holds an item.
// reset (synchronous, active high) empties all stages; no state carries over.
`default_nettype none
`include "tilt_compensated_compass_heading_top_macros.svh"
module tilt_compensated_compass_heading_top
   import tcch_pkg::*;
(
   input  wire logic  clock,
   input  wire logic  reset,
   tcch_req_if.sink   req_if,
   tcch_rsp_if.source rsp_if
);

   // plain stage payloads
   typedef struct packed {
      logic signed [15:0] cr, sr, cp, sp, mx, my, mz;
   } m0_type;
   typedef struct packed {
      logic signed [31:0] pa, pb, pc, pd, pe;
      logic signed [15:0] sp;
   } m1_type;
   typedef struct packed {
      logic signed [47:0] t1, t2, t3, hy;
   } m2_type;
   typedef struct packed {
      logic signed [47:0] hx, hy;
   } m3_type;
   typedef struct packed {
      logic signed [15:0]   head;
      logic signed [ZW-1:0] angc;
   } hd_type;
   typedef struct packed {
      logic signed [15:0]   head;
      logic signed [ZW-1:0] angc;
      logic [41:0]          t;
      logic [47:0]          p;
   } p2_type;
   typedef struct packed {
      logic signed [15:0]   head;
      logic signed [ZW-1:0] angc;
      logic [15:0]          q0;
      logic [42:0]          r;
   } p3_type;
   typedef struct packed {
      logic signed [15:0]   head;
      logic signed [ZW-1:0] angc;
      logic [15:0]          course;
   } p4_type;
   typedef struct packed {
      logic signed [15:0] heading;
      logic [15:0]        course;
      logic signed [15:0] hcos;
      logic signed [15:0] hsin;
   } out_type;

   // ---------------- chain wiring ----------------
   lane_type [LANES-1:0] a_lane [NUM_ITER+1];
   logic [SIDE_W-1:0]    a_side [NUM_ITER+1];
   logic                 a_v    [NUM_ITER+1];
   logic                 a_r    [NUM_ITER+1];
   lane_type [LANES-1:0] b_lane [NUM_ITER+1];
   logic [SIDE_W-1:0]    b_side [NUM_ITER+1];
   logic                 b_v    [NUM_ITER+1];
   logic                 b_r    [NUM_ITER+1];
   lane_type [LANES-1:0] c_lane [NUM_ITER+1];
   logic [SIDE_W-1:0]    c_side [NUM_ITER+1];
   logic                 c_v    [NUM_ITER+1];
   logic                 c_r    [NUM_ITER+1];

   // chain heads
   lane_type [LANES-1:0] a_lane0, b_lane0, c_lane0;
   logic [SIDE_W-1:0]    a_side0, b_side0, c_side0;

   logic    m0_v_ff, m1_v_ff, m2_v_ff, m3_v_ff;
   logic    m0_r, m1_r, m2_r, m3_r;
   m0_type  m0_ff, m0_in;
   m1_type  m1_ff, m1_in;
   m2_type  m2_ff, m2_in;
   m3_type  m3_ff, m3_in;

   logic                 p0_v_ff, p1_v_ff, p2_v_ff, p3_v_ff, p4_v_ff, o_v_ff;
   logic                 p0_r, p1_r, p2_r, p3_r, p4_r, o_r;
   logic signed [ZW-1:0] p0_ff, p0_in;
   hd_type               p1_ff, p1_in;
   p2_type               p2_ff, p2_in;
   p3_type               p3_ff, p3_in;
   p4_type               p4_ff, p4_in;
   out_type              o_ff, o_in;

   // ---------------- roll / pitch sin-cos prep ----------------
   always_comb begin
      logic signed [ZW-1:0] zr;
      logic signed [ZW-1:0] zp;
      side_a_type           sa;
      zr = $signed({{5{req_if.roll[15]}}, req_if.roll, 11'b0});
      zp = $signed({{5{req_if.pitch[15]}}, req_if.pitch, 11'b0});
      sa.pad  = '0;
      sa.mx   = req_if.mag_x;
      sa.my   = req_if.mag_y;
      sa.mz   = req_if.mag_z;
      sa.negr = 1'b0;
      sa.negp = 1'b0;
      // fold by pi into the cordic range
      if (zr > HALF_PI_Z) begin
         zr = zr - PI_Z;
         sa.negr = 1'b1;
      end else if (zr < -HALF_PI_Z) begin
         zr = zr + PI_Z;
         sa.negr = 1'b1;
      end
      if (zp > HALF_PI_Z) begin
         zp = zp - PI_Z;
         sa.negp = 1'b1;
      end else if (zp < -HALF_PI_Z) begin
         zp = zp + PI_Z;
         sa.negp = 1'b1;
      end
      a_lane0[0].x = GAIN_X;
      a_lane0[0].y = '0;
      a_lane0[0].z = zr;
      a_lane0[1].x = GAIN_X;
      a_lane0[1].y = '0;
      a_lane0[1].z = zp;
      a_side0 = sa;
   end
   assign a_lane[0]    = a_lane0;
   assign a_side[0]    = a_side0;
   assign a_v[0]       = req_if.valid;
   assign req_if.ready = a_r[0];

   // ---------------- three cordic chains ----------------
   for (genvar gi = 0; gi < NUM_ITER; gi++) begin : g_cells
      tcch_cell u_a (
         .clock, .reset,
         .ctl      (cell_ctl_type'{mode: MODE_ROT, idx: 5'(gi)}),
         .in_valid (a_v[gi]),   .in_ready (a_r[gi]),
         .in_lane  (a_lane[gi]), .in_side (a_side[gi]),
         .out_valid(a_v[gi+1]), .out_ready(a_r[gi+1]),
         .out_lane (a_lane[gi+1]), .out_side(a_side[gi+1])
      );
      tcch_cell u_b (
         .clock, .reset,
         .ctl      (cell_ctl_type'{mode: MODE_VEC, idx: 5'(gi)}),
         .in_valid (b_v[gi]),   .in_ready (b_r[gi]),
         .in_lane  (b_lane[gi]), .in_side (b_side[gi]),
         .out_valid(b_v[gi+1]), .out_ready(b_r[gi+1]),
         .out_lane (b_lane[gi+1]), .out_side(b_side[gi+1])
      );
      tcch_cell u_c (
         .clock, .reset,
         .ctl      (cell_ctl_type'{mode: MODE_ROT, idx: 5'(gi)}),
         .in_valid (c_v[gi]),   .in_ready (c_r[gi]),
         .in_lane  (c_lane[gi]), .in_side (c_side[gi]),
         .out_valid(c_v[gi+1]), .out_ready(c_r[gi+1]),
         .out_lane (c_lane[gi+1]), .out_side(c_side[gi+1])
      );
   end

   // ---------------- tilt compensation ----------------
   // ready chain: a stage may load when empty or when its successor loads
   assign a_r[NUM_ITER] = m0_r;
   assign m0_r = !m0_v_ff || m1_r;
   assign m1_r = !m1_v_ff || m2_r;
   assign m2_r = !m2_v_ff || m3_r;
   assign m3_r = !m3_v_ff || b_r[0];

   always_comb begin
      side_a_type sa;
      sa = side_a_type'(a_side[NUM_ITER]);
      m0_in.cr = to_q14(a_lane[NUM_ITER][0].x, sa.negr);
      m0_in.sr = to_q14(a_lane[NUM_ITER][0].y, sa.negr);
      m0_in.cp = to_q14(a_lane[NUM_ITER][1].x, sa.negp);
      m0_in.sp = to_q14(a_lane[NUM_ITER][1].y, sa.negp);
      m0_in.mx = sa.mx;
      m0_in.my = sa.my;
      m0_in.mz = sa.mz;
   end

   always_comb begin
      m1_in.pa = m0_ff.mx * m0_ff.cp;
      m1_in.pb = m0_ff.my * m0_ff.sr;
      m1_in.pc = m0_ff.mz * m0_ff.cr;
      m1_in.pd = m0_ff.my * m0_ff.cr;
      m1_in.pe = m0_ff.mz * m0_ff.sr;
      m1_in.sp = m0_ff.sp;
   end

   always_comb begin
      m2_in.t1 = m1_ff.pa <<< 14;
      m2_in.t2 = m1_ff.pb * m1_ff.sp;
      m2_in.t3 = m1_ff.pc * m1_ff.sp;
      m2_in.hy = (m1_ff.pd - m1_ff.pe) <<< 14;
   end

   always_comb begin
      m3_in.hx = m2_ff.t1 + m2_ff.t2 + m2_ff.t3;
      m3_in.hy = m2_ff.hy;
   end

   // ---------------- atan2(-hy, hx) prep ----------------
   always_comb begin
      logic signed [XW-1:0] vx;
      logic signed [XW-1:0] vy;
      side_b_type           sb;
      vx = XW'(m3_ff.hx);
      vy = -(XW'(m3_ff.hy));
      sb.pad  = '0;
      sb.zero = (m3_ff.hx == 0) && (m3_ff.hy == 0);
      sb.base = BASE_NONE;
      // left half plane: turn by pi first
      if (vx < 0) begin
         sb.base = (vy > 0) ? BASE_POS : BASE_NEG;
         vx = -vx;
         vy = -vy;
      end
      b_lane0[0].x = vx;
      b_lane0[0].y = vy;
      b_lane0[0].z = '0;
      b_lane0[1]   = '0;
      b_side0      = sb;
   end
   assign b_lane[0] = b_lane0;
   assign b_side[0] = b_side0;
   assign b_v[0]    = m3_v_ff;

   // ---------------- heading and course ----------------
   assign b_r[NUM_ITER] = p0_r;
   assign p0_r = !p0_v_ff || p1_r;
   assign p1_r = !p1_v_ff || p2_r;
   assign p2_r = !p2_v_ff || p3_r;
   assign p3_r = !p3_v_ff || p4_r;
   assign p4_r = !p4_v_ff || c_r[0];

   always_comb begin
      side_b_type sb;
      sb = side_b_type'(b_side[NUM_ITER]);
      case (sb.base)
         BASE_POS: p0_in = b_lane[NUM_ITER][0].z + PI_Z;
         BASE_NEG: p0_in = b_lane[NUM_ITER][0].z - PI_Z;
         default:  p0_in = b_lane[NUM_ITER][0].z;
      endcase
      // zero field reads as heading zero
      if (sb.zero) begin
         p0_in = '0;
      end
   end

   always_comb begin
      logic signed [ZW-1:0] hr;
      if (p0_ff >= 0) begin
         hr = (p0_ff + 32'sd1024) >>> 11;
      end else begin
         hr = -((-p0_ff + 32'sd1024) >>> 11);
      end
      if (hr > ZW'(HEAD_MAX)) begin
         hr = ZW'(HEAD_MAX);
      end else if (hr < -(ZW'(HEAD_MAX))) begin
         hr = -(ZW'(HEAD_MAX));
      end
      p1_in.head = 16'(hr);
      if (p0_ff > PI_Z) begin
         p1_in.angc = PI_Z;
      end else if (p0_ff < -PI_Z) begin
         p1_in.angc = -PI_Z;
      end else begin
         p1_in.angc = p0_ff;
      end
   end

   // course = 18000 + floor(head * 36864000 / pi), via reciprocal and one fixup
   always_comb begin
      logic [15:0] habs;
      habs = p1_ff.head[15] ? 16'(-p1_ff.head) : 16'(p1_ff.head);
      p2_in.head = p1_ff.head;
      p2_in.angc = p1_ff.angc;
      p2_in.t    = habs * COURSE_K;
      p2_in.p    = habs * RECIP;
   end

   always_comb begin
      logic [42:0] qpi;
      qpi = p2_ff.p[47:32] * PI_U;
      p3_in.head = p2_ff.head;
      p3_in.angc = p2_ff.angc;
      p3_in.q0   = p2_ff.p[47:32];
      p3_in.r    = 43'(p2_ff.t) - qpi;
   end

   always_comb begin
      logic               ge;
      logic               rz;
      logic signed [17:0] q;
      logic signed [17:0] f;
      logic signed [17:0] c;
      ge = p3_ff.r >= 43'(PI_U);
      rz = ge ? (p3_ff.r == 43'(PI_U)) : (p3_ff.r == 43'd0);
      q  = $signed({2'b00, p3_ff.q0}) + $signed({17'd0, ge});
      // negative heading floors away from zero on an inexact quotient
      if (p3_ff.head[15]) begin
         f = -(q + $signed({17'd0, !rz}));
      end else begin
         f = q;
      end
      c = 18'sd18000 + f;
      if (c < 18'sd0) begin
         c = 18'sd0;
      end else if (c > 18'sd36000) begin
         c = 18'sd36000;
      end
      p4_in.head   = p3_ff.head;
      p4_in.angc   = p3_ff.angc;
      p4_in.course = 16'(c);
   end

   // ---------------- heading cos/sin prep ----------------
   always_comb begin
      logic signed [ZW-1:0] z;
      side_c_type           sc;
      z = p4_ff.angc;
      sc.pad    = '0;
      sc.head   = p4_ff.head;
      sc.course = p4_ff.course;
      sc.neg    = 1'b0;
      if (z > HALF_PI_Z) begin
         z = z - PI_Z;
         sc.neg = 1'b1;
      end else if (z < -HALF_PI_Z) begin
         z = z + PI_Z;
         sc.neg = 1'b1;
      end
      c_lane0[0].x = GAIN_X;
      c_lane0[0].y = '0;
      c_lane0[0].z = z;
      c_lane0[1]   = '0;
      c_side0      = sc;
   end
   assign c_lane[0] = c_lane0;
   assign c_side[0] = c_side0;
   assign c_v[0]    = p4_v_ff;

   // ---------------- output register ----------------
   assign c_r[NUM_ITER] = o_r;
   assign o_r = !o_v_ff || rsp_if.ready;

   always_comb begin
      side_c_type sc;
      sc = side_c_type'(c_side[NUM_ITER]);
      o_in.heading = sc.head;
      o_in.course  = sc.course;
      o_in.hcos    = to_q14(c_lane[NUM_ITER][0].x, sc.neg);
      o_in.hsin    = to_q14(c_lane[NUM_ITER][0].y, sc.neg);
   end

   // ---------------- stage registers ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         m0_v_ff <= 1'b0;
         m1_v_ff <= 1'b0;
         m2_v_ff <= 1'b0;
         m3_v_ff <= 1'b0;
         p0_v_ff <= 1'b0;
         p1_v_ff <= 1'b0;
         p2_v_ff <= 1'b0;
         p3_v_ff <= 1'b0;
         p4_v_ff <= 1'b0;
         o_v_ff  <= 1'b0;
      end else begin
         if (m0_r) m0_v_ff <= a_v[NUM_ITER];
         if (m1_r) m1_v_ff <= m0_v_ff;
         if (m2_r) m2_v_ff <= m1_v_ff;
         if (m3_r) m3_v_ff <= m2_v_ff;
         if (p0_r) p0_v_ff <= b_v[NUM_ITER];
         if (p1_r) p1_v_ff <= p0_v_ff;
         if (p2_r) p2_v_ff <= p1_v_ff;
         if (p3_r) p3_v_ff <= p2_v_ff;
         if (p4_r) p4_v_ff <= p3_v_ff;
         if (o_r)  o_v_ff  <= c_v[NUM_ITER];
      end
      if (m0_r && a_v[NUM_ITER]) m0_ff <= m0_in;
      if (m1_r && m0_v_ff)       m1_ff <= m1_in;
      if (m2_r && m1_v_ff)       m2_ff <= m2_in;
      if (m3_r && m2_v_ff)       m3_ff <= m3_in;
      if (p0_r && b_v[NUM_ITER]) p0_ff <= p0_in;
      if (p1_r && p0_v_ff)       p1_ff <= p1_in;
      if (p2_r && p1_v_ff)       p2_ff <= p2_in;
      if (p3_r && p2_v_ff)       p3_ff <= p3_in;
      if (p4_r && p3_v_ff)       p4_ff <= p4_in;
      if (o_r && c_v[NUM_ITER])  o_ff  <= o_in;
   end

   assign rsp_if.valid           = o_v_ff;
   assign rsp_if.heading         = o_ff.heading;
   assign rsp_if.course_centideg = o_ff.course;
   assign rsp_if.heading_cos     = o_ff.hcos;
   assign rsp_if.heading_sin     = o_ff.hsin;

   // ---------------- checks ----------------
   `TCCH_ASSERT_IMP(a_course_range, clock, reset, rsp_if.valid,
      rsp_if.course_centideg <= 16'd36000, "course beyond full circle")
   `TCCH_ASSERT_IMP(a_course_north, clock, reset, rsp_if.valid && rsp_if.heading == 16'sd0,
      rsp_if.course_centideg == 16'd18000, "zero heading gives wrong course")
   `TCCH_ASSERT_IMP(a_course_back, clock, reset,
      rsp_if.valid && rsp_if.heading == -16'sd25736,
      rsp_if.course_centideg == 16'd0, "heading at minus pi gives wrong course")
   `TCCH_ASSERT_IMP(a_full_chain, clock, reset, !req_if.ready,
      rsp_if.valid && !rsp_if.ready, "input stalled while output not blocked")

endmodule
`default_nettype wire

### test/tcch_tb_if.sv
`timescale 1ns / 1ps
// the block's own interfaces (tcch_req_if, tcch_rsp_if) come with the rtl;
// this file carries the shared result record used by the testbench
package tcch_tb_pkg;
   typedef struct packed {
      logic signed [15:0] heading;
      logic [15:0]        course;
      logic signed [15:0] hcos;
      logic signed [15:0] hsin;
   } heading_rec_type;
endpackage

### test/testbench.sv
`timescale 1ns / 1ps
module testbench;
   import tcch_tb_pkg::*;

   localparam int STAGES = 16;
   localparam int NITER  = (STAGES < 24) ? STAGES : 24;
   localparam int LATENCY = 3 * STAGES + 10;

   localparam longint PI_A    = 52707179;
   localparam longint HPI_A   = 26353589;
   localparam longint GAIN_V  = 652032874;
   localparam longint ONE14   = 16384;
   localparam longint HMAX    = 25736;

   typedef struct packed {
      logic signed [15:0] mx;
      logic signed [15:0] my;
      logic signed [15:0] mz;
      logic signed [15:0] roll;
      logic signed [15:0] pitch;
   } sample_type;

   // idle phases for sender and receiver, in percent
   typedef enum int {
      PH_NONE,
      PH_SEND_IDLE,
      PH_RECV_STALL,
      PH_BOTH
   } idle_phase_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   tcch_req_if req_if ();
   tcch_rsp_if rsp_if ();

   tilt_compensated_compass_heading_top DUT (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if.sink),
      .rsp_if (rsp_if.source)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   sample_type      pending_samples[$];
   heading_rec_type expected_headings[$];
   idle_phase_type  phase = PH_NONE;
   int              mismatches = 0;
   int              results_seen = 0;
   int              hold_cycles = 0;   // long receiver hold-off, counted below
   bit              sender_pause = 1'b0;
   bit              stim_done = 1'b0;

   // arctan table in 2^-24 rad
   function automatic longint atan_tab(input int i);
      longint t[24] = '{13176795, 7778716, 4110060, 2086331, 1047214, 524117, 262123,
                        131069, 65536, 32768, 16384, 8192, 4096, 2048, 1024, 512,
                        256, 128, 64, 32, 16, 8, 4, 2};
      return t[i];
   endfunction

   function automatic longint floor_shift(input longint v, input int s);
      return v >>> s;
   endfunction

   function automatic longint round_shift(input longint v, input int s);
      longint h;
      h = longint'(1) << (s - 1);
      if (v >= 0) return (v + h) >>> s;
      return -((-v + h) >>> s);
   endfunction

   function automatic longint limit(input longint v, input longint lo, input longint hi);
      return v < lo ? lo : (v > hi ? hi : v);
   endfunction

   // rotation cordic: angle in 2^-24 rad to q1.14 cos/sin
   function automatic void rotate_unit(input longint ang, output longint c,
                                       output longint s);
      longint x, y, z, t;
      bit     flip;
      x = GAIN_V; y = 0; z = ang; flip = 0;
      if (z > HPI_A) begin
         z -= PI_A; flip = 1;
      end else if (z < -HPI_A) begin
         z += PI_A; flip = 1;
      end
      for (int i = 0; i < NITER; i++) begin
         t = x;
         if (z >= 0) begin
            x -= floor_shift(y, i); y += floor_shift(t, i); z -= atan_tab(i);
         end else begin
            x += floor_shift(y, i); y -= floor_shift(t, i); z += atan_tab(i);
         end
      end
      if (flip) begin
         x = -x; y = -y;
      end
      c = limit(round_shift(x, 16), -ONE14, ONE14);
      s = limit(round_shift(y, 16), -ONE14, ONE14);
   endfunction

   // vectoring cordic: atan2(y, x) in 2^-24 rad
   function automatic longint field_angle(input longint y0, input longint x0);
      longint x, y, z, t, base;
      x = x0; y = y0; z = 0; base = 0;
      if (x == 0 && y == 0) return 0;
      if (x < 0) begin
         base = (y > 0) ? PI_A : -PI_A;
         x = -x; y = -y;
      end
      for (int i = 0; i < NITER; i++) begin
         t = x;
         if (y > 0) begin
            x += floor_shift(y, i); y -= floor_shift(t, i); z += atan_tab(i);
         end else begin
            x -= floor_shift(y, i); y += floor_shift(t, i); z -= atan_tab(i);
         end
      end
      return z + base;
   endfunction

   function automatic heading_rec_type predict_heading(input sample_type s);
      longint cr, sr, cp, sp, hx, hy, ang, head, num, course, hc, hs;
      heading_rec_type r;
      rotate_unit(longint'(s.roll) * 2048, cr, sr);
      rotate_unit(longint'(s.pitch) * 2048, cp, sp);
      hx = longint'(s.mx) * cp * ONE14 + longint'(s.my) * sr * sp
         + longint'(s.mz) * cr * sp;
      hy = (longint'(s.my) * cr - longint'(s.mz) * sr) * ONE14;
      ang = field_angle(-hy, hx);
      head = limit(round_shift(ang, 11), -HMAX, HMAX);
      num = (head * 2048 + PI_A) * 18000;
      course = (num > 0) ? num / PI_A : 0;
      course = limit(course, 0, 36000);
      rotate_unit(limit(ang, -PI_A, PI_A), hc, hs);
      r.heading = 16'(head);
      r.course  = 16'(course);
      r.hcos    = 16'(hc);
      r.hsin    = 16'(hs);
      return r;
   endfunction

   function automatic int idle_pct(input bit sender);
      case (phase)
         PH_SEND_IDLE:  return sender ? 60 : 0;
         PH_RECV_STALL: return sender ? 0 : 60;
         PH_BOTH:       return 25;
         default:       return 0;
      endcase
   endfunction

   // driver: offer the next pending item unless idling
   always @(posedge clock) begin
      if (reset) begin
         req_if.valid <= 1'b0;
      end else begin
         if (req_if.valid && req_if.ready) begin
            expected_headings.push_back(predict_heading({req_if.mag_x, req_if.mag_y,
               req_if.mag_z, req_if.roll, req_if.pitch}));
         end
         if (!req_if.valid || req_if.ready) begin
            if (pending_samples.size() > 0 && !sender_pause
                && $urandom_range(99) >= idle_pct(1'b1)) begin
               sample_type s;
               s = pending_samples.pop_front();
               req_if.valid <= 1'b1;
               req_if.mag_x <= s.mx;
               req_if.mag_y <= s.my;
               req_if.mag_z <= s.mz;
               req_if.roll  <= s.roll;
               req_if.pitch <= s.pitch;
            end else begin
               req_if.valid <= 1'b0;
            end
         end
      end
   end

   // long hold-off on the result side, so the pipeline fills and stalls its input
   always @(posedge clock) begin
      if (hold_cycles > 0) hold_cycles <= hold_cycles - 1;
   end

   // monitor: check each accepted result against the oldest prediction
   always @(posedge clock) begin
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else begin
         if (rsp_if.valid && rsp_if.ready) begin
            heading_rec_type want;
            heading_rec_type got;
            got = '{rsp_if.heading, rsp_if.course_centideg, rsp_if.heading_cos,
                    rsp_if.heading_sin};
            results_seen <= results_seen + 1;
            if (expected_headings.size() == 0) begin
               mismatches <= mismatches + 1;
               if (mismatches < 10)
                  $display("unexpected result heading=%0d course=%0d cos=%0d sin=%0d",
                           got.heading, got.course, got.hcos, got.hsin);
            end else begin
               want = expected_headings.pop_front();
               if (got !== want) begin
                  mismatches <= mismatches + 1;
                  if (mismatches < 10)
                     $display({"mismatch: heading %0d/%0d course %0d/%0d ",
                               "cos %0d/%0d sin %0d/%0d (exp/act)"},
                              want.heading, got.heading, want.course, got.course,
                              want.hcos, got.hcos, want.hsin, got.hsin);
               end
            end
         end
         rsp_if.ready <= (hold_cycles <= 1) && ($urandom_range(99) >= idle_pct(1'b0));
      end
   end

   function automatic logic signed [15:0] rand_angle();
      return 16'($urandom_range(51472) - 25736);
   endfunction

   function automatic sample_type rand_sample(input bit wide_angles);
      sample_type s;
      s.mx = 16'($urandom);
      s.my = 16'($urandom);
      s.mz = 16'($urandom);
      if ($urandom_range(9) == 0) begin
         // small fields exercise rounding near zero
         s.mx = 16'($urandom_range(6) - 3);
         s.my = 16'($urandom_range(6) - 3);
         s.mz = 16'($urandom_range(6) - 3);
      end
      s.roll  = wide_angles ? 16'($urandom) : rand_angle();
      s.pitch = wide_angles ? 16'($urandom) : rand_angle();
      return s;
   endfunction

   task automatic drain();
      while (pending_samples.size() > 0 || req_if.valid || expected_headings.size() > 0)
         @(posedge clock);
   endtask

   initial begin
      sample_type s;
      req_if.valid = 1'b0;
      req_if.mag_x = '0; req_if.mag_y = '0; req_if.mag_z = '0;
      req_if.roll  = '0; req_if.pitch = '0;
      rsp_if.ready = 1'b0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // directed: zero field, exactly behind, axis extremes, angle extremes, wide angles
      pending_samples.push_back('{16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0});
      pending_samples.push_back('{-16'sd1000, 16'sd0, 16'sd0, 16'sd0, 16'sd0});
      pending_samples.push_back('{-16'sd32768, 16'sd0, 16'sd0, 16'sd0, 16'sd0});
      pending_samples.push_back('{16'sd32767, 16'sd0, 16'sd0, 16'sd0, 16'sd0});
      pending_samples.push_back('{16'sd0, 16'sd32767, 16'sd0, 16'sd0, 16'sd0});
      pending_samples.push_back('{16'sd0, -16'sd32768, 16'sd0, 16'sd0, 16'sd0});
      pending_samples.push_back('{-16'sd32768, 16'sd1, 16'sd0, 16'sd0, 16'sd0});
      pending_samples.push_back('{-16'sd32768, -16'sd1, 16'sd0, 16'sd0, 16'sd0});
      pending_samples.push_back('{16'sd100, 16'sd200, 16'sd32767, 16'sd25736, 16'sd25736});
      pending_samples.push_back('{16'sd100, 16'sd200, -16'sd32768, -16'sd25736, -16'sd25736});
      pending_samples.push_back('{16'sd500, -16'sd500, 16'sd300, 16'sd32767, -16'sd32768});
      pending_samples.push_back('{-16'sd32768, -16'sd32768, -16'sd32768, -16'sd32768,
                                  16'sd32767});
      pending_samples.push_back('{16'sd32767, 16'sd32767, 16'sd32767, 16'sd12868, -16'sd12868});
      pending_samples.push_back('{16'sd1, 16'sd0, 16'sd0, 16'sd0, 16'sd0});
      pending_samples.push_back('{16'sd0, 16'sd0, 16'sd1000, 16'sd0, 16'sd0});
      pending_samples.push_back('{16'sd0, 16'sd0, 16'sd1000, 16'sd0, 16'sd12868});
      pending_samples.push_back('{16'sd0, 16'sd0, 16'sd1000, 16'sd12868, 16'sd0});
      pending_samples.push_back('{16'sd0, 16'sd0, 16'sd0, 16'sd25736, 16'sd25736});
      drain();

      // random phases with different idling
      for (int p = 0; p < 4; p++) begin
         phase = idle_phase_type'(p);
         for (int n = 0; n < 450; n++)
            pending_samples.push_back(rand_sample($urandom_range(4) == 0));
         if (p == 0) begin
            // receiver holds off while the sender keeps offering every cycle
            hold_cycles = 3 * LATENCY;
         end
         if (p == 2) begin
            // sender waits for everything outstanding to come back
            while (pending_samples.size() > 225) @(posedge clock);
            sender_pause = 1'b1;
            while (req_if.valid || expected_headings.size() > 0) @(posedge clock);
            sender_pause = 1'b0;
         end
         drain();
      end
      repeat (LATENCY + 10) @(posedge clock);

      $display("covered %0d results: zero field, behind, clamp cases, wide angles,",
               results_seen);
      $display("sender/receiver idling phases, long receiver hold-off and sender drain pause");
      if (mismatches == 0 && expected_headings.size() == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

   initial begin
      #20ms;
      $display("DONE: errors detected");
      $finish;
   end
endmodule
